@@ hdl/eilhp_pkg.sv @@
// Package with shared types, constants and verdict codes for the header parser.
`default_nettype none
package eilhp_pkg;
  localparam int unsigned MaxFrameDefault = 65535;

  typedef enum logic [3:0] {
    VERDICT_TCP_OK      = 4'd0,
    VERDICT_UDP_OK      = 4'd1,
    VERDICT_SHORT_ETH   = 4'd2,
    VERDICT_IGNORED     = 4'd3,
    VERDICT_UNKNOWN     = 4'd4,
    VERDICT_SHORT_IP    = 4'd5,
    VERDICT_NOT_V4      = 4'd6,
    VERDICT_SHORT_L4    = 4'd7,
    VERDICT_TCP_SHORT   = 4'd8,
    VERDICT_UDP_SHORT   = 4'd9,
    VERDICT_OTHER       = 4'd10
  } verdict_t;

  localparam logic [15:0] EtherIpv4 = 16'h0800;
  localparam logic [15:0] EtherVlan = 16'h8100;
  localparam logic [15:0] EtherArp  = 16'h0806;
  localparam logic [15:0] EtherRarp = 16'h8035;
  localparam logic [15:0] EtherIpv6 = 16'h86DD;
  localparam logic [15:0] EtherEapol = 16'h888E;
  localparam logic [4:0]  NetStartIpv4 = 5'd14;
  localparam logic [4:0]  NetStartVlan = 5'd18;
  localparam logic [7:0]  ProtoTcp = 8'd6;
  localparam logic [7:0]  ProtoUdp = 8'd17;
  localparam logic [3:0]  IpVersion4 = 4'd4;

  // Frame summary handed from the front part to the back part.
  typedef struct packed {
    logic [16:0] len;
    logic [15:0] ether_kind;
    logic [4:0]  net_start;
    logic [3:0]  ip_version;
    logic [3:0]  net_header_words;
    logic [7:0]  transport_proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [3:0]  seg_header_words;
    logic [7:0]  flags;
    logic [15:0] wire_len;
  } summary_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic [7:0]  flags_byte;
    logic [7:0]  payload_offset;
    logic [15:0] frame_wire_len;
  } result_t;
endpackage
`default_nettype wire

@@ hdl/eilhp_if.sv @@
// Valid/ready channel interfaces for frame bytes and verdicts.
`default_nettype none
interface eilhp_byte_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last;
  logic [15:0] wire_len;
  modport source (output valid, data_byte, last, wire_len, input ready);
  modport sink (input valid, data_byte, last, wire_len, output ready);
endinterface

interface eilhp_verdict_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [31:0] source_address;
  logic [15:0] source_port;
  logic [31:0] dest_address;
  logic [15:0] dest_port;
  logic [7:0]  flags_byte;
  logic [7:0]  payload_offset;
  logic [15:0] frame_wire_len;
  modport source (output valid, verdict, source_address, source_port, dest_address,
    dest_port, flags_byte, payload_offset, frame_wire_len, input ready);
  modport sink (input valid, verdict, source_address, source_port, dest_address,
    dest_port, flags_byte, payload_offset, frame_wire_len, output ready);
endinterface
`default_nettype wire

@@ hdl/eth_ipv4_l4_header_parser.sv @@
// Top level of the Ethernet/IPv4/TCP-UDP header parser.
//
//   channel   direction  contents
//   in_ch     sink       one frame byte per request, last, wire_len
//   out_ch    source     one verdict per frame with addresses and ports
//   cfg       write      min_payload, written with cfg_we
//
// One byte is taken per cycle while ready; a verdict passes summary, queue and result registers.
// The front part captures fields as bytes arrive and hands a summary to a two-entry queue.
// Only a last byte can be refused, and only while the queue has no entry left for its summary.
// A stalled verdict holds the back part, and the queue absorbs up to two more frames.
// Reset is synchronous and clears min_payload, captured fields, queue fill and valid flags.
`default_nettype none
module eth_ipv4_l4_header_parser #(
  parameter int unsigned MAX_FRAME = eilhp_pkg::MaxFrameDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  eilhp_byte_if.sink         in_ch,
  eilhp_verdict_if.source    out_ch,
  input  wire logic          cfg_we,
  input  wire logic [11:0]   cfg_data
);
  logic [11:0]          min_payload;
  logic                 in_fire;
  eilhp_pkg::summary_t  front_summary;
  logic                 front_valid;
  eilhp_pkg::summary_t  queue_data;
  logic                 queue_not_empty;
  logic                 queue_room;
  logic                 back_take;
  eilhp_pkg::result_t   result;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_payload <= '0;
    end else if (cfg_we) begin
      min_payload <= cfg_data;
    end
  end

  // The last byte needs a queue entry once the summary in flight and this cycle's pop count.
  assign in_ch.ready = !in_ch.last ||
    (!front_valid && (queue_room || back_take)) ||
    (front_valid && (!queue_not_empty || (queue_room && back_take)));
  assign in_fire = in_ch.valid && in_ch.ready;

  eilhp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk(clk), .rst(rst), .in_fire(in_fire), .data_byte(in_ch.data_byte),
    .last(in_ch.last), .wire_len(in_ch.wire_len), .summary(front_summary),
    .summary_valid(front_valid)
  );

  eilhp_queue u_queue (
    .clk(clk), .rst(rst), .push(front_valid), .push_data(front_summary),
    .pop(back_take), .pop_data(queue_data), .not_empty(queue_not_empty),
    .has_room(queue_room)
  );

  eilhp_back u_back (
    .clk(clk), .rst(rst), .min_payload(min_payload), .summary(queue_data),
    .summary_valid(queue_not_empty), .summary_take(back_take), .result(result),
    .result_valid(out_ch.valid), .result_ready(out_ch.ready)
  );

  assign out_ch.verdict = result.verdict;
  assign out_ch.source_address = result.source_address;
  assign out_ch.source_port = result.source_port;
  assign out_ch.dest_address = result.dest_address;
  assign out_ch.dest_port = result.dest_port;
  assign out_ch.flags_byte = result.flags_byte;
  assign out_ch.payload_offset = result.payload_offset;
  assign out_ch.frame_wire_len = result.frame_wire_len;
endmodule
`default_nettype wire

@@ hdl/eilhp_front.sv @@
// Front part: captures header fields byte by byte and emits a frame summary.
`default_nettype none
module eilhp_front #(
  parameter int unsigned MAX_FRAME = eilhp_pkg::MaxFrameDefault
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_fire,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last,
  input  wire logic [15:0]       wire_len,
  output eilhp_pkg::summary_t    summary,
  output logic                   summary_valid
);
  localparam logic [15:0] MaxCount = 16'(MAX_FRAME);

  logic [15:0] byte_count;
  logic [15:0] ether_kind;
  logic [4:0]  net_start;
  logic [3:0]  ip_version;
  logic [3:0]  net_header_words;
  logic [7:0]  transport_proto;
  logic [31:0] src_addr_reg;
  logic [31:0] dst_addr_reg;
  logic [15:0] src_port_reg;
  logic [15:0] dst_port_reg;
  logic [3:0]  seg_header_words;
  logic [7:0]  flag_reg;

  logic        counting;
  logic [15:0] count_next;
  logic [15:0] ether_next;
  logic [4:0]  start_next;
  logic [3:0]  ver_next;
  logic [3:0]  ihl_next;
  logic [7:0]  proto_next;
  logic [31:0] src_next;
  logic [31:0] dst_next;
  logic [15:0] sport_next;
  logic [15:0] dport_next;
  logic [3:0]  doff_next;
  logic [7:0]  flag_next;
  logic [15:0] rel;
  logic [15:0] tpos;
  logic [16:0] len;

  always_comb begin
    counting = byte_count < MaxCount;
    count_next = byte_count;
    ether_next = ether_kind;
    start_next = net_start;
    ver_next = ip_version;
    ihl_next = net_header_words;
    proto_next = transport_proto;
    src_next = src_addr_reg;
    dst_next = dst_addr_reg;
    sport_next = src_port_reg;
    dport_next = dst_port_reg;
    doff_next = seg_header_words;
    flag_next = flag_reg;
    rel = byte_count - {11'd0, net_start};
    tpos = '0;
    if (counting) begin
      count_next = byte_count + 16'd1;
      if (byte_count == 16'd12) begin
        ether_next = {data_byte, 8'd0};
      end else if (byte_count == 16'd13) begin
        ether_next = {ether_kind[15:8], data_byte};
        if (ether_next == eilhp_pkg::EtherIpv4) begin
          start_next = eilhp_pkg::NetStartIpv4;
        end else if (ether_next == eilhp_pkg::EtherVlan) begin
          start_next = eilhp_pkg::NetStartVlan;
        end else begin
          start_next = 5'd0;
        end
      end else if (net_start != 5'd0 && byte_count >= {11'd0, net_start}) begin
        if (rel == 16'd0) begin
          ver_next = data_byte[7:4];
          ihl_next = data_byte[3:0];
        end else if (rel == 16'd9) begin
          proto_next = data_byte;
        end else if (rel >= 16'd12 && rel < 16'd16) begin
          src_next = {src_addr_reg[23:0], data_byte};
        end else if (rel >= 16'd16 && rel < 16'd20) begin
          dst_next = {dst_addr_reg[23:0], data_byte};
        end
        tpos = rel - {10'd0, ihl_next, 2'b00};
        if (rel >= {10'd0, ihl_next, 2'b00}) begin
          if (tpos < 16'd2) begin
            sport_next = {src_port_reg[7:0], data_byte};
          end else if (tpos < 16'd4) begin
            dport_next = {dst_port_reg[7:0], data_byte};
          end else if (tpos == 16'd12) begin
            doff_next = data_byte[7:4];
          end else if (tpos == 16'd13) begin
            flag_next = data_byte;
          end
        end
      end
    end
    len = (count_next < wire_len) ? {1'b0, count_next} : {1'b0, wire_len};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      summary_valid <= 1'b0;
    end else begin
      summary_valid <= in_fire && last;
    end
    if (in_fire && last) begin
      summary <= '{len: len, ether_kind: ether_next, net_start: start_next,
        ip_version: ver_next, net_header_words: ihl_next, transport_proto: proto_next,
        src_addr: src_next, dst_addr: dst_next, src_port: sport_next,
        dst_port: dport_next, seg_header_words: doff_next, flags: flag_next,
        wire_len: wire_len};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && last)) begin
      byte_count <= '0;
      ether_kind <= '0;
      net_start <= '0;
      ip_version <= '0;
      net_header_words <= '0;
      transport_proto <= '0;
      src_addr_reg <= '0;
      dst_addr_reg <= '0;
      src_port_reg <= '0;
      dst_port_reg <= '0;
      seg_header_words <= '0;
      flag_reg <= '0;
    end else if (in_fire) begin
      byte_count <= count_next;
      ether_kind <= ether_next;
      net_start <= start_next;
      ip_version <= ver_next;
      net_header_words <= ihl_next;
      transport_proto <= proto_next;
      src_addr_reg <= src_next;
      dst_addr_reg <= dst_next;
      src_port_reg <= sport_next;
      dst_port_reg <= dport_next;
      seg_header_words <= doff_next;
      flag_reg <= flag_next;
    end
  end
endmodule
`default_nettype wire

@@ hdl/eilhp_queue.sv @@
// Two-entry queue between the front and back parts.
`default_nettype none
module eilhp_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire eilhp_pkg::summary_t push_data,
  input  wire logic                pop,
  output eilhp_pkg::summary_t      pop_data,
  output logic                     not_empty,
  output logic                     has_room
);
  eilhp_pkg::summary_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign not_empty = fill != 2'd0;
  assign has_room = fill != 2'd2;
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

@@ hdl/eilhp_back.sv @@
// Back part: classifies a frame summary into a verdict held in an output register.
`default_nettype none
module eilhp_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [11:0]         min_payload,
  input  wire eilhp_pkg::summary_t summary,
  input  wire logic                summary_valid,
  output logic                     summary_take,
  output eilhp_pkg::result_t       result,
  output logic                     result_valid,
  input  wire logic                result_ready
);
  eilhp_pkg::result_t r;
  logic [17:0] tstart;
  logic [17:0] data;
  logic [17:0] len;

  assign summary_take = summary_valid && (!result_valid || result_ready);

  always_comb begin
    len = {1'b0, summary.len};
    tstart = {13'd0, summary.net_start} + {12'd0, summary.net_header_words, 2'b00};
    data = '0;
    r = '0;
    r.frame_wire_len = summary.wire_len;
    if (len < 18'd14) begin
      r.verdict = eilhp_pkg::VERDICT_SHORT_ETH;
    end else if (summary.net_start == 5'd0) begin
      if (summary.ether_kind == eilhp_pkg::EtherArp ||
          summary.ether_kind == eilhp_pkg::EtherRarp ||
          summary.ether_kind == eilhp_pkg::EtherIpv6 ||
          summary.ether_kind == eilhp_pkg::EtherEapol) begin
        r.verdict = eilhp_pkg::VERDICT_IGNORED;
      end else begin
        r.verdict = eilhp_pkg::VERDICT_UNKNOWN;
      end
    end else if ({13'd0, summary.net_start} + 18'd20 > len) begin
      r.verdict = eilhp_pkg::VERDICT_SHORT_IP;
    end else if (summary.ip_version != eilhp_pkg::IpVersion4) begin
      r.verdict = eilhp_pkg::VERDICT_NOT_V4;
    end else begin
      r.source_address = summary.src_addr;
      r.dest_address = summary.dst_addr;
      if (summary.transport_proto == eilhp_pkg::ProtoTcp) begin
        if (tstart + 18'd20 > len) begin
          r.verdict = eilhp_pkg::VERDICT_SHORT_L4;
        end else begin
          data = tstart + {12'd0, summary.seg_header_words, 2'b00};
          r.source_port = summary.src_port;
          r.dest_port = summary.dst_port;
          r.flags_byte = summary.flags;
          r.payload_offset = data[7:0];
          r.verdict = (data + {6'd0, min_payload} > len) ?
            eilhp_pkg::VERDICT_TCP_SHORT : eilhp_pkg::VERDICT_TCP_OK;
        end
      end else if (summary.transport_proto == eilhp_pkg::ProtoUdp) begin
        if (tstart + 18'd8 > len) begin
          r.verdict = eilhp_pkg::VERDICT_SHORT_L4;
        end else begin
          data = tstart + 18'd8;
          r.source_port = summary.src_port;
          r.dest_port = summary.dst_port;
          r.payload_offset = data[7:0];
          r.verdict = (data + {6'd0, min_payload} > len) ?
            eilhp_pkg::VERDICT_UDP_SHORT : eilhp_pkg::VERDICT_UDP_OK;
        end
      end else begin
        r.verdict = eilhp_pkg::VERDICT_OTHER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (summary_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (summary_take) begin
      result <= r;
    end
  end
endmodule
`default_nettype wire

@@ sim/tb_scoreboard.sv @@
// Verdict scoreboard: frame header predictor and queue of expected verdicts.
class verdict_scoreboard;
  eilhp_pkg::result_t pending_q[$];
  int errors;
  logic [11:0] min_payload;
  int unsigned count, kind, nstart, ver, ihl, proto, saddr, daddr, sport, dport, doff, flg;

  function void clear_frame();
    count = 0; kind = 0; nstart = 0; ver = 0; ihl = 0; proto = 0;
    saddr = 0; daddr = 0; sport = 0; dport = 0; doff = 0; flg = 0;
  endfunction

  function void set_min_payload(logic [11:0] v);
    min_payload = v;
  endfunction

  function void capture_byte(int unsigned p, int unsigned b);
    int unsigned rel, t;
    if (p == 12) begin
      kind = b << 8;
    end else if (p == 13) begin
      kind = kind | b;
      if (kind == eilhp_pkg::EtherIpv4) nstart = 14;
      else if (kind == eilhp_pkg::EtherVlan) nstart = 18;
      else nstart = 0;
    end else if (nstart != 0 && p >= nstart) begin
      rel = p - nstart;
      if (rel == 0) begin
        ver = b >> 4; ihl = b & 15;
      end else if (rel == 9) begin
        proto = b;
      end else if (rel >= 12 && rel < 16) begin
        saddr = (saddr << 8) | b;
      end else if (rel >= 16 && rel < 20) begin
        daddr = (daddr << 8) | b;
      end
      if (rel >= ihl * 4) begin
        t = rel - ihl * 4;
        if (t < 2) sport = ((sport << 8) | b) & 16'hFFFF;
        else if (t < 4) dport = ((dport << 8) | b) & 16'hFFFF;
        else if (t == 12) doff = b >> 4;
        else if (t == 13) flg = b;
      end
    end
  endfunction

  function void note_request(logic [7:0] b, logic lst, logic [15:0] wl);
    eilhp_pkg::result_t r;
    int unsigned len, t, data;
    bit a_ok, p_ok, f_ok, d_ok;
    a_ok = 0; p_ok = 0; f_ok = 0; d_ok = 0; data = 0;
    if (count < 65535) begin
      capture_byte(count, b);
      count++;
    end
    if (!lst) return;
    len = (count < wl) ? count : wl;
    if (len < 14) r.verdict = eilhp_pkg::VERDICT_SHORT_ETH;
    else if (nstart == 0) begin
      if (kind == eilhp_pkg::EtherArp || kind == eilhp_pkg::EtherRarp ||
          kind == eilhp_pkg::EtherIpv6 || kind == eilhp_pkg::EtherEapol)
        r.verdict = eilhp_pkg::VERDICT_IGNORED;
      else r.verdict = eilhp_pkg::VERDICT_UNKNOWN;
    end else if (nstart + 20 > len) r.verdict = eilhp_pkg::VERDICT_SHORT_IP;
    else if (ver != 4) r.verdict = eilhp_pkg::VERDICT_NOT_V4;
    else begin
      a_ok = 1;
      t = nstart + ihl * 4;
      if (proto == eilhp_pkg::ProtoTcp) begin
        if (t + 20 > len) r.verdict = eilhp_pkg::VERDICT_SHORT_L4;
        else begin
          p_ok = 1; f_ok = 1; d_ok = 1;
          data = t + doff * 4;
          r.verdict = (data + min_payload > len) ? eilhp_pkg::VERDICT_TCP_SHORT
                                                 : eilhp_pkg::VERDICT_TCP_OK;
        end
      end else if (proto == eilhp_pkg::ProtoUdp) begin
        if (t + 8 > len) r.verdict = eilhp_pkg::VERDICT_SHORT_L4;
        else begin
          p_ok = 1; d_ok = 1;
          data = t + 8;
          r.verdict = (data + min_payload > len) ? eilhp_pkg::VERDICT_UDP_SHORT
                                                 : eilhp_pkg::VERDICT_UDP_OK;
        end
      end else r.verdict = eilhp_pkg::VERDICT_OTHER;
    end
    r.source_address = a_ok ? saddr : 0;
    r.dest_address = a_ok ? daddr : 0;
    r.source_port = p_ok ? sport : 0;
    r.dest_port = p_ok ? dport : 0;
    r.flags_byte = f_ok ? flg : 0;
    r.payload_offset = d_ok ? data[7:0] : 0;
    r.frame_wire_len = wl;
    pending_q.push_back(r);
    clear_frame();
  endfunction

  function void check_verdict(eilhp_pkg::result_t got);
    eilhp_pkg::result_t e;
    if (pending_q.size() == 0) begin
      $error("verdict with none expected: %h", got);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got.verdict != e.verdict) begin
      $error("verdict: expected %0d, actual %0d", e.verdict, got.verdict); errors++;
    end
    if (got.source_address != e.source_address) begin
      $error("source_address: expected %h, actual %h", e.source_address,
             got.source_address); errors++;
    end
    if (got.source_port != e.source_port) begin
      $error("source_port: expected %h, actual %h", e.source_port, got.source_port);
      errors++;
    end
    if (got.dest_address != e.dest_address) begin
      $error("dest_address: expected %h, actual %h", e.dest_address, got.dest_address);
      errors++;
    end
    if (got.dest_port != e.dest_port) begin
      $error("dest_port: expected %h, actual %h", e.dest_port, got.dest_port); errors++;
    end
    if (got.flags_byte != e.flags_byte) begin
      $error("flags_byte: expected %h, actual %h", e.flags_byte, got.flags_byte); errors++;
    end
    if (got.payload_offset != e.payload_offset) begin
      $error("payload_offset: expected %0d, actual %0d", e.payload_offset,
             got.payload_offset); errors++;
    end
    if (got.frame_wire_len != e.frame_wire_len) begin
      $error("frame_wire_len: expected %0d, actual %0d", e.frame_wire_len,
             got.frame_wire_len); errors++;
    end
  endfunction
endclass

@@ sim/tb.sv @@
// Testbench top: drives frames into the header parser and checks every verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [11:0] cfg_data = 0;
  int unsigned cycle = 0;
  int unsigned sent = 0;
  verdict_scoreboard sb;

  eilhp_byte_if in_ch();
  eilhp_verdict_if out_ch();

  eth_ipv4_l4_header_parser u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.data_byte = 0;
    in_ch.last = 0;
    in_ch.wire_len = 0;
    out_ch.ready = 0;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("[eth_ipv4_l4_header_parser] ERROR");
      $finish;
    end
  end

  // Receiver side: random stalls, sampling at the edge.
  initial begin
    int unsigned s;
    @(posedge clk);
    forever begin
      s = gap_len();
      out_ch.ready <= (s == 0);
      do begin
        @(posedge clk);
        if (out_ch.valid && out_ch.ready)
          sb.check_verdict('{out_ch.verdict, out_ch.source_address, out_ch.source_port,
                             out_ch.dest_address, out_ch.dest_port, out_ch.flags_byte,
                             out_ch.payload_offset, out_ch.frame_wire_len});
        if (s > 0) s--;
      end while (s > 0);
    end
  end

  task automatic send_request(logic [7:0] b, logic lst, logic [15:0] wl, bit quiet);
    int unsigned g;
    g = quiet ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data_byte <= b;
    in_ch.last <= lst;
    in_ch.wire_len <= wl;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(b, lst, wl);
    sent++;
  endtask

  // Builds and sends a frame; kind selects the shape, len the number of bytes sent.
  task automatic send_frame(int unsigned kind, int unsigned len, int signed wdelta,
                            bit quiet);
    logic [7:0] fr[];
    int unsigned ns, ihl, doff, t, i;
    logic [15:0] wl;
    fr = new[len];
    foreach (fr[k]) fr[k] = $urandom_range(0, 255);
    ns = ($urandom_range(0, 3) == 0) ? 18 : 14;
    ihl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 7);
    doff = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 8);
    if (kind < 6) begin
      if (len > 13) begin
        fr[12] = (ns == 18) ? 8'h81 : 8'h08;
        fr[13] = 8'h00;
      end
      if (len > ns) fr[ns] = {($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4, 4'(ihl)};
      if (len > ns + 9)
        fr[ns + 9] = (kind < 3) ? eilhp_pkg::ProtoTcp :
                     (kind < 5) ? eilhp_pkg::ProtoUdp : 8'($urandom);
      t = ns + ihl * 4 + 12;
      if (kind < 3 && len > t && t >= ns + 10) fr[t] = {4'(doff), 4'($urandom)};
    end else if (kind == 6 && len > 13) begin
      case ($urandom_range(0, 3))
        0: {fr[12], fr[13]} = eilhp_pkg::EtherArp;
        1: {fr[12], fr[13]} = eilhp_pkg::EtherRarp;
        2: {fr[12], fr[13]} = eilhp_pkg::EtherIpv6;
        default: {fr[12], fr[13]} = eilhp_pkg::EtherEapol;
      endcase
    end
    if (wdelta < 0 && len < -wdelta) wl = 0;
    else wl = 16'(int'(len) + wdelta);
    for (i = 0; i < len; i++) send_request(fr[i], i == len - 1, wl, quiet);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_min_payload(logic [11:0] v);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_min_payload(v);
  endtask

  task automatic random_frame();
    int unsigned k, len, r;
    int signed wd;
    k = $urandom_range(0, 9);
    r = $urandom_range(0, 99);
    len = (r < 8) ? $urandom_range(1, 40) : (r < 98) ? $urandom_range(34, 90)
                                                    : $urandom_range(100, 160);
    r = $urandom_range(0, 9);
    wd = (r < 6) ? 0 : (r < 8) ? int'($urandom_range(1, 3000))
                              : -int'($urandom_range(1, 30));
    if (r == 9 && $urandom_range(0, 3) == 0) wd = 65535 - int'(len);
    send_frame(k, len, wd, 0);
  endtask

  initial begin
    logic [11:0] mp[5];
    sb = new();
    sb.errors = 0;
    sb.min_payload = 0;
    sb.clear_frame();
    mp = '{12'd0, 12'd2048, 12'd20, 12'd4095, 12'd1};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed frames at reset setting of zero minimum payload.
    send_frame(0, 60, 0, 1);
    send_frame(3, 42, 0, 1);
    send_frame(5, 40, 0, 1);
    send_frame(6, 20, 0, 1);
    send_frame(9, 20, 0, 1);
    send_frame(0, 13, 0, 1);
    send_frame(0, 1, 0, 1);
    send_frame(0, 30, 0, 1);
    send_frame(0, 60, -40, 1);
    send_frame(0, 70, 65535 - 70, 1);
    send_frame(3, 20, 0, 1);
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_min_payload(mp[p]);
      while (sent < 1450 * (p + 1) / 5) random_frame();
    end
    wait_idle();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[eth_ipv4_l4_header_parser] OK");
    end else begin
      $display("[eth_ipv4_l4_header_parser] ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/eilhp_pkg.sv
hdl/eilhp_if.sv
hdl/eilhp_front.sv
hdl/eilhp_queue.sv
hdl/eilhp_back.sv
hdl/eth_ipv4_l4_header_parser.sv
sim/tb_scoreboard.sv
sim/tb.sv
